// ===== rtl/core/pwfm_pkg.sv =====
// shared types and constants of the posted wait / frame matcher
package pwfm_pkg;

   localparam int WAIT_DEPTH  = 32;
   localparam int FRAME_DEPTH = 64;
   localparam int MAX_RESULTS = 32;
   localparam int LIMIT_W     = 7;
   localparam int LIMIT_RESET = 64;

   localparam int WAIT_AW  = $clog2(WAIT_DEPTH);
   localparam int FRAME_AW = $clog2(FRAME_DEPTH);
   localparam int WCNT_W   = $clog2(WAIT_DEPTH + 1);
   localparam int FCNT_W   = $clog2(FRAME_DEPTH + 1);
   localparam int RES_W    = $clog2(MAX_RESULTS + 1);
   localparam int CNT_A_W  = (FCNT_W > WCNT_W) ? FCNT_W : WCNT_W;
   localparam int SCAN_W   = (CNT_A_W > RES_W) ? CNT_A_W : RES_W;
   localparam int CALC_W   = ((SCAN_W > LIMIT_W) ? SCAN_W : LIMIT_W) + 1;

   typedef enum logic [1:0] {
      OP_POST  = 2'd0,
      OP_FRAME = 2'd1,
      OP_FAIL  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RC_DELIVER = 2'd0,
      RC_FAIL    = 2'd1,
      RC_DROP    = 2'd2,
      RC_REJECT  = 2'd3
   } code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_EV,
      S_FIN,
      S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      SCAN_POST,
      SCAN_FRAME,
      SCAN_DROP,
      SCAN_FAIL
   } scan_type;

   typedef struct packed {
      logic [7:0]  peer;
      logic        sig;
      logic [63:0] tag;
      logic [31:0] rid;
      logic [63:0] dest;
   } wait_entry_type;

   typedef struct packed {
      logic        sig;
      logic [63:0] tag;
      logic [15:0] handle;
      logic [31:0] len;
   } frame_entry_type;

   typedef struct packed {
      code_type    code;
      logic [31:0] rid;
      logic [63:0] dest;
      logic [15:0] handle;
      logic [31:0] len;
   } result_type;

   typedef struct packed {
      logic        a_sig;
      logic [63:0] a_tag;
      logic        b_sig;
      logic [63:0] b_tag;
      logic [7:0]  a_peer;
      logic [7:0]  b_peer;
   } cmp_in_type;

   typedef struct packed {
      logic kind_hit;
      logic peer_hit;
   } cmp_out_type;

endpackage

// ===== rtl/core/pwfm_wait_mem.sv =====
// wait store memory, one write and one registered read port
module pwfm_wait_mem import pwfm_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [WAIT_AW-1:0]   wr_addr,
   input  wait_entry_type       wr_data,
   input  logic                 rd_en,
   input  logic [WAIT_AW-1:0]   rd_addr,
   output wait_entry_type       rd_data
);

   wait_entry_type mem_ff [WAIT_DEPTH];
   wait_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pwfm_frame_mem.sv =====
// frame store memory, one write and one registered read port
module pwfm_frame_mem import pwfm_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [FRAME_AW-1:0]  wr_addr,
   input  frame_entry_type      wr_data,
   input  logic                 rd_en,
   input  logic [FRAME_AW-1:0]  rd_addr,
   output frame_entry_type      rd_data
);

   frame_entry_type mem_ff [FRAME_DEPTH];
   frame_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pwfm_match_unit.sv =====
// shared compare unit: kind and tag match, peer match
module pwfm_match_unit import pwfm_pkg::*; (
   input  cmp_in_type  cmp_in,
   output cmp_out_type cmp_out
);

   always_comb begin
      cmp_out.kind_hit = (cmp_in.a_sig == cmp_in.b_sig) &&
                         (!cmp_in.a_sig || (cmp_in.a_tag == cmp_in.b_tag));
      cmp_out.peer_hit = (cmp_in.a_peer == cmp_in.b_peer);
   end

endmodule

// ===== rtl/core/posted_wait_frame_matcher_core.sv =====
// top level of the posted wait / frame matcher: sequencer, scan and result path
//
//   channel   direction   handshake                 carries
//   req_      in          req_valid / req_stall     one operation per beat
//   rsp_      out         rsp_valid / rsp_stall     one result per beat, last marks the end
//   csr_      in          csr_write_enable          frame_limit
//
// an operation scans one store entry at a time (registered memory read, then compare
// and compaction write); req_stall stays high until the operation has finished
// a frame that drops old frames scans the wait store and then the frame store
// reset clears counts and sequencer, sets limit to LIMIT_RESET; stores need no clearing
// a stalled rsp_ holds the scan only when a second result is ready to leave
module posted_wait_frame_matcher_core import pwfm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_operation,
   input  logic [7:0]   req_peer,
   input  logic         req_is_signal,
   input  logic [63:0]  req_tag,
   input  logic [31:0]  req_request_id,
   input  logic [63:0]  req_dest_address,
   input  logic [15:0]  req_buffer_handle,
   input  logic [31:0]  req_payload_length,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_result_code,
   output logic [31:0]  rsp_out_request_id,
   output logic [63:0]  rsp_out_dest_address,
   output logic [15:0]  rsp_out_buffer_handle,
   output logic [31:0]  rsp_out_length,
   output logic         rsp_last,
   input  logic         csr_write_enable,
   input  logic [6:0]   csr_write_data
);

   state_type state_ff, state_in;
   scan_type  kind_ff, kind_in;

   logic [LIMIT_W-1:0] limit_ff;
   logic [SCAN_W-1:0]  wcnt_ff, wcnt_in;
   logic [SCAN_W-1:0]  fcnt_ff, fcnt_in;
   logic [SCAN_W-1:0]  r_ff, r_in;
   logic [SCAN_W-1:0]  nrem_ff, nrem_in;
   logic [SCAN_W-1:0]  d_ff, d_in;

   logic [7:0]  peer_ff;
   logic        sig_ff;
   logic [63:0] tag_ff;
   logic [31:0] rid_ff;
   logic [63:0] dest_ff;
   logic [15:0] handle_ff;
   logic [31:0] len_ff;

   result_type held_ff, held_in;
   logic       held_valid_ff, held_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_last_ff, rsp_last_in;

   logic accept;
   logic rsp_free;
   logic scan_frames;
   logic [SCAN_W-1:0] cnt_sel;
   logic [SCAN_W-1:0] wr_ptr;
   logic rm;
   logic stall_emit;
   logic [63:0] wdest;
   result_type new_res;

   logic [CALC_W-1:0] lim;
   logic [CALC_W-1:0] fcnt_x;
   logic [CALC_W-1:0] diff;
   logic [SCAN_W-1:0] d_calc;

   logic            wm_wr_en, wm_rd_en;
   logic [WAIT_AW-1:0] wm_wr_addr;
   wait_entry_type  wm_wr_data, wm_rd_data;
   logic            fm_wr_en, fm_rd_en;
   logic [FRAME_AW-1:0] fm_wr_addr;
   frame_entry_type fm_wr_data, fm_rd_data;

   cmp_in_type  cmp_in;
   cmp_out_type cmp_out;

   pwfm_wait_mem u_wait_mem (
      .clock   (clock),
      .wr_en   (wm_wr_en),
      .wr_addr (wm_wr_addr),
      .wr_data (wm_wr_data),
      .rd_en   (wm_rd_en),
      .rd_addr (r_ff[WAIT_AW-1:0]),
      .rd_data (wm_rd_data)
   );

   pwfm_frame_mem u_frame_mem (
      .clock   (clock),
      .wr_en   (fm_wr_en),
      .wr_addr (fm_wr_addr),
      .wr_data (fm_wr_data),
      .rd_en   (fm_rd_en),
      .rd_addr (r_ff[FRAME_AW-1:0]),
      .rd_data (fm_rd_data)
   );

   pwfm_match_unit u_match (
      .cmp_in  (cmp_in),
      .cmp_out (cmp_out)
   );

   assign accept      = req_valid && (state_ff == S_IDLE);
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign scan_frames = (kind_ff == SCAN_POST) || (kind_ff == SCAN_DROP);
   assign cnt_sel     = scan_frames ? fcnt_ff : wcnt_ff;
   assign wr_ptr      = r_ff - nrem_ff;
   assign wdest       = sig_ff ? 64'd0 : dest_ff;

   // compare operands
   always_comb begin
      cmp_in.a_sig  = sig_ff;
      cmp_in.a_tag  = tag_ff;
      cmp_in.a_peer = peer_ff;
      cmp_in.b_peer = wm_rd_data.peer;
      if (scan_frames) begin
         cmp_in.b_sig = fm_rd_data.sig;
         cmp_in.b_tag = fm_rd_data.tag;
      end else begin
         cmp_in.b_sig = wm_rd_data.sig;
         cmp_in.b_tag = wm_rd_data.tag;
      end
   end

   // remove decision and result of the entry under evaluation
   always_comb begin
      new_res = '0;
      rm      = 1'b0;
      case (kind_ff)
         SCAN_POST: begin
            rm             = (nrem_ff == '0) && cmp_out.kind_hit;
            new_res.code   = RC_DELIVER;
            new_res.rid    = rid_ff;
            new_res.dest   = wdest;
            new_res.handle = fm_rd_data.handle;
            new_res.len    = fm_rd_data.len;
         end
         SCAN_FRAME: begin
            rm             = (nrem_ff == '0) && cmp_out.kind_hit;
            new_res.code   = RC_DELIVER;
            new_res.rid    = wm_rd_data.rid;
            new_res.dest   = wm_rd_data.dest;
            new_res.handle = handle_ff;
            new_res.len    = len_ff;
         end
         SCAN_DROP: begin
            rm             = (nrem_ff < d_ff);
            new_res.code   = RC_DROP;
            new_res.handle = fm_rd_data.handle;
            new_res.len    = fm_rd_data.len;
         end
         SCAN_FAIL: begin
            rm           = cmp_out.peer_hit && (nrem_ff < SCAN_W'(MAX_RESULTS));
            new_res.code = RC_FAIL;
            new_res.rid  = wm_rd_data.rid;
         end
         default: begin
            rm = 1'b0;
         end
      endcase
   end

   assign stall_emit = rm && held_valid_ff && !rsp_free;

   // number of frames to drop before storing an unmatched frame
   always_comb begin
      if (limit_ff == '0) begin
         lim = CALC_W'(1);
      end else if (CALC_W'(limit_ff) > CALC_W'(FRAME_DEPTH)) begin
         lim = CALC_W'(FRAME_DEPTH);
      end else begin
         lim = CALC_W'(limit_ff);
      end
      fcnt_x = CALC_W'(fcnt_ff);
      diff   = fcnt_x - lim + CALC_W'(1);
      if (fcnt_x < lim) begin
         d_calc = '0;
      end else if (diff > CALC_W'(MAX_RESULTS)) begin
         d_calc = SCAN_W'(MAX_RESULTS);
      end else begin
         d_calc = diff[SCAN_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (op_type'(req_operation) != OP_NONE)) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = (r_ff == cnt_sel) ? S_FIN : S_EV;
         end
         S_EV: begin
            state_in = stall_emit ? S_EV : S_RD;
         end
         S_FIN: begin
            if ((kind_ff == SCAN_FRAME) && (nrem_ff == '0) && (d_calc != '0)) begin
               state_in = S_RD;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!held_valid_ff || rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      kind_in       = kind_ff;
      wcnt_in       = wcnt_ff;
      fcnt_in       = fcnt_ff;
      r_in          = r_ff;
      nrem_in       = nrem_ff;
      d_in          = d_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      wm_rd_en   = 1'b0;
      fm_rd_en   = 1'b0;
      wm_wr_en   = 1'b0;
      fm_wr_en   = 1'b0;
      wm_wr_addr = wr_ptr[WAIT_AW-1:0];
      fm_wr_addr = wr_ptr[FRAME_AW-1:0];
      wm_wr_data = wm_rd_data;
      fm_wr_data = fm_rd_data;

      case (state_ff)
         S_IDLE: begin
            r_in    = '0;
            nrem_in = '0;
            case (op_type'(req_operation))
               OP_POST:  kind_in = SCAN_POST;
               OP_FRAME: kind_in = SCAN_FRAME;
               OP_FAIL:  kind_in = SCAN_FAIL;
               default:  kind_in = kind_ff;
            endcase
         end
         S_RD: begin
            wm_rd_en = !scan_frames;
            fm_rd_en = scan_frames;
         end
         S_EV: begin
            if (!stall_emit) begin
               r_in = r_ff + SCAN_W'(1);
               if (rm) begin
                  nrem_in       = nrem_ff + SCAN_W'(1);
                  held_in       = new_res;
                  held_valid_in = 1'b1;
                  if (held_valid_ff) begin
                     rsp_in       = held_ff;
                     rsp_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
               end else if (nrem_ff != '0) begin
                  // compaction
                  wm_wr_en = !scan_frames;
                  fm_wr_en = scan_frames;
               end
            end
         end
         S_FIN: begin
            case (kind_ff)
               SCAN_POST: begin
                  if (nrem_ff != '0) begin
                     fcnt_in = fcnt_ff - SCAN_W'(1);
                  end else if (wcnt_ff >= SCAN_W'(WAIT_DEPTH)) begin
                     held_in.code   = RC_REJECT;
                     held_in.rid    = rid_ff;
                     held_in.dest   = '0;
                     held_in.handle = '0;
                     held_in.len    = '0;
                     held_valid_in  = 1'b1;
                  end else begin
                     wm_wr_en        = 1'b1;
                     wm_wr_addr      = wcnt_ff[WAIT_AW-1:0];
                     wm_wr_data.peer = peer_ff;
                     wm_wr_data.sig  = sig_ff;
                     wm_wr_data.tag  = tag_ff;
                     wm_wr_data.rid  = rid_ff;
                     wm_wr_data.dest = wdest;
                     wcnt_in         = wcnt_ff + SCAN_W'(1);
                  end
               end
               SCAN_FRAME: begin
                  if (nrem_ff != '0) begin
                     wcnt_in = wcnt_ff - SCAN_W'(1);
                  end else if (d_calc != '0) begin
                     kind_in = SCAN_DROP;
                     d_in    = d_calc;
                     r_in    = '0;
                     nrem_in = '0;
                  end else if (fcnt_ff < SCAN_W'(FRAME_DEPTH)) begin
                     fm_wr_en          = 1'b1;
                     fm_wr_addr        = fcnt_ff[FRAME_AW-1:0];
                     fm_wr_data.sig    = sig_ff;
                     fm_wr_data.tag    = tag_ff;
                     fm_wr_data.handle = handle_ff;
                     fm_wr_data.len    = len_ff;
                     fcnt_in           = fcnt_ff + SCAN_W'(1);
                  end
               end
               SCAN_DROP: begin
                  if ((fcnt_ff - nrem_ff) < SCAN_W'(FRAME_DEPTH)) begin
                     fm_wr_en          = 1'b1;
                     fm_wr_addr        = wr_ptr[FRAME_AW-1:0];
                     fm_wr_data.sig    = sig_ff;
                     fm_wr_data.tag    = tag_ff;
                     fm_wr_data.handle = handle_ff;
                     fm_wr_data.len    = len_ff;
                     fcnt_in           = fcnt_ff - nrem_ff + SCAN_W'(1);
                  end else begin
                     fcnt_in = fcnt_ff - nrem_ff;
                  end
               end
               SCAN_FAIL: begin
                  wcnt_in = wcnt_ff - nrem_ff;
               end
               default: begin
                  wcnt_in = wcnt_ff;
               end
            endcase
         end
         S_FLUSH: begin
            if (held_valid_ff && rsp_free) begin
               rsp_in        = held_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               held_valid_in = 1'b0;
            end
         end
         default: begin
            r_in = r_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         kind_ff       <= SCAN_POST;
         limit_ff      <= LIMIT_W'(LIMIT_RESET);
         wcnt_ff       <= '0;
         fcnt_ff       <= '0;
         r_ff          <= '0;
         nrem_ff       <= '0;
         d_ff          <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kind_ff       <= kind_in;
         wcnt_ff       <= wcnt_in;
         fcnt_ff       <= fcnt_in;
         r_ff          <= r_in;
         nrem_ff       <= nrem_in;
         d_ff          <= d_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      if (accept) begin
         peer_ff   <= req_peer;
         sig_ff    <= req_is_signal;
         tag_ff    <= req_tag;
         rid_ff    <= req_request_id;
         dest_ff   <= req_dest_address;
         handle_ff <= req_buffer_handle;
         len_ff    <= req_payload_length;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_code       = rsp_ff.code;
   assign rsp_out_request_id    = rsp_ff.rid;
   assign rsp_out_dest_address  = rsp_ff.dest;
   assign rsp_out_buffer_handle = rsp_ff.handle;
   assign rsp_out_length        = rsp_ff.len;
   assign rsp_last              = rsp_last_ff;

endmodule
